@@ rtl/itrd_pkg.sv @@
`default_nettype none

package itrd_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int MAX_DIGITS_DEF  = 32;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_TOP   = 6'd35;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA  = 7'd55;  // 'A' - 10

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_LOAD
    } itrd_state_t;

    // divider status seen by the sequencer
    typedef struct packed {
        logic done;
        logic quo_zero;
    } itrd_div_sts_t;

    // clamp radix to 2..36
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] v;
        begin
            v = r;
            if (v < RADIX_MIN) begin
                v = RADIX_MIN;
            end
            if (v > RADIX_MAX) begin
                v = RADIX_MAX;
            end
            return v;
        end
    endfunction

    // digit value to ASCII, 0-9 then A-Z
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] v;
        begin
            v = (d > DIGIT_TOP) ? DIGIT_TOP : d;
            if (v < DIGIT_TEN) begin
                return CHAR_ZERO + {1'b0, v};
            end
            return CHAR_ALPHA + {1'b0, v};
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/itrd_ram.sv @@
`default_nettype none

module itrd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/itrd_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle, small divisor.
module itrd_div #(
    parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [VALUE_WIDTH-1:0]        dividend,
    input  wire logic [itrd_pkg::RADIX_W-1:0]  divisor,
    output logic      [VALUE_WIDTH-1:0]        quotient,
    output logic      [itrd_pkg::DIGIT_W-1:0]  remainder,
    output itrd_pkg::itrd_div_sts_t            sts
);

    localparam int STEP_W = $clog2(VALUE_WIDTH);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [VALUE_WIDTH-1:0]       quo_reg, quo_next;
    logic [itrd_pkg::DIGIT_W-1:0] rem_reg, rem_next;
    logic [itrd_pkg::DIGIT_W:0]   trial;
    logic [itrd_pkg::DIGIT_W:0]   diff;
    logic                         fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        diff      = trial - {1'b0, divisor};
        fits      = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(VALUE_WIDTH - 1);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_next  = fits ? diff[itrd_pkg::DIGIT_W-1:0] : trial[itrd_pkg::DIGIT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient     = quo_reg;
    assign remainder    = rem_reg;
    assign sts.done     = done_reg;
    assign sts.quo_zero = (quo_reg == '0);

endmodule

`default_nettype wire

@@ rtl/integer_to_radix_digits_top.sv @@
`default_nettype none

// Integer to ASCII digit string converter, radix 2 to 36.
//
// Input channel (in_valid/in_ready, number): one non-negative value per item.
// Output channel (out_valid/out_ready, char_code, is_last): one ASCII digit
// per item, most significant first; is_last marks the final digit. Zero
// gives the single digit '0'.
// Config: cfg_wen/cfg_wdata writes the radix register (reset 10). Values
// 0 and 1 act as 2, values above 36 act as 36. Write only while idle.
//
// Conversion: a value needing D digits is divided D times by a bit-serial
// restoring divider, then each digit is read back from the digit RAM
// through the ST_RD and ST_LOAD states. D is at most 10 in radix 10
// and 31 in radix 2 at the default width.
// in_ready is low for the whole conversion.
// The output register lets a new item be accepted while the last digit
// waits; a stalled receiver holds the digit readout, nothing is dropped.
// Reset clears the sequencer, output valid and sets the radix to 10.
module integer_to_radix_digits_top #(
    parameter int VALUE_WIDTH = itrd_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = itrd_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wen,
    input  wire logic [itrd_pkg::RADIX_W-1:0]    cfg_wdata,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [VALUE_WIDTH-1:0]          number,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [itrd_pkg::CHAR_W-1:0]     char_code,
    output logic                                 is_last
);

    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    itrd_pkg::itrd_state_t state_reg, state_next;

    logic [itrd_pkg::RADIX_W-1:0] radix_reg;
    logic [itrd_pkg::RADIX_W-1:0] radix_eff;
    logic [CNT_W-1:0]             digit_count_reg, digit_count_next;
    logic [CNT_W-1:0]             count_inc;
    logic [CNT_W-1:0]             count_dec;
    logic [IDX_W-1:0]             idx_reg, idx_next;

    logic                         out_valid_reg, out_valid_next;
    logic [itrd_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                         last_reg, last_next;

    logic                         div_start;
    logic [VALUE_WIDTH-1:0]       div_dividend;
    logic [VALUE_WIDTH-1:0]       div_quotient;
    logic [itrd_pkg::DIGIT_W-1:0] div_remainder;
    itrd_pkg::itrd_div_sts_t      div_sts;

    logic                         ram_we;
    logic [itrd_pkg::DIGIT_W-1:0] ram_rdata;

    assign radix_eff = itrd_pkg::eff_radix(radix_reg);

    itrd_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_eff),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .sts       (div_sts)
    );

    // remainders, least significant digit at address 0
    itrd_ram #(
        .WIDTH(itrd_pkg::DIGIT_W),
        .DEPTH(MAX_DIGITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (digit_count_reg[IDX_W-1:0]),
        .wdata (div_remainder),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        digit_count_next = digit_count_reg;
        idx_next         = idx_reg;
        div_start        = 1'b0;
        div_dividend     = number;
        ram_we           = 1'b0;
        count_inc        = digit_count_reg;
        count_dec        = '0;
        out_valid_next   = out_valid_reg && !out_ready;
        char_next        = char_reg;
        last_next        = last_reg;

        unique case (state_reg)
            itrd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    div_start        = 1'b1;
                    digit_count_next = '0;
                    state_next       = itrd_pkg::ST_DIV;
                end
            end
            itrd_pkg::ST_DIV:
            begin
                if (div_sts.done)
                begin
                    // digits beyond the store are dropped, division goes on
                    if (digit_count_reg < CNT_W'(MAX_DIGITS))
                    begin
                        ram_we    = 1'b1;
                        count_inc = digit_count_reg + CNT_W'(1);
                    end
                    digit_count_next = count_inc;
                    if (div_sts.quo_zero)
                    begin
                        count_dec  = count_inc - CNT_W'(1);
                        idx_next   = count_dec[IDX_W-1:0];
                        state_next = itrd_pkg::ST_RD;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = div_quotient;
                    end
                end
            end
            itrd_pkg::ST_RD:
            begin
                state_next = itrd_pkg::ST_LOAD;
            end
            itrd_pkg::ST_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itrd_pkg::digit_char(ram_rdata);
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = itrd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = itrd_pkg::ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = itrd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= itrd_pkg::ST_IDLE;
            radix_reg       <= itrd_pkg::RADIX_RESET;
            digit_count_reg <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            digit_count_reg <= digit_count_next;
            idx_reg         <= idx_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wen)
            begin
                radix_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign in_ready  = (state_reg == itrd_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign is_last   = last_reg;

endmodule

`default_nettype wire

@@ rtl/itrd_chk.sv @@
`default_nettype none

module itrd_chk (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [itrd_pkg::CHAR_W-1:0] char_code,
    input wire logic                        is_last
);

    // block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready still high after item accepted");

    // stalled digit holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(is_last))
        else $error("output item changed while stalled");

    // only 0-9 and A-Z
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code >= 7'd48 && char_code <= 7'd57) ||
                      (char_code >= 7'd65 && char_code <= 7'd90))
        else $error("char_code outside digit set");

endmodule

bind integer_to_radix_digits_top itrd_chk u_itrd_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .is_last   (is_last)
);

`default_nettype wire

@@ test/tb_integer_to_radix_digits_top.sv @@
module tb_integer_to_radix_digits_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = itrd_pkg::VALUE_WIDTH_DEF;
    localparam int RW          = itrd_pkg::RADIX_W;
    localparam int HOLD_CYCLES = 2500;   // long receiver hold-off, well above one conversion

    // one expected output item: a digit and its last flag
    typedef struct packed {
        logic [itrd_pkg::CHAR_W-1:0] char_code;
        logic                        is_last;
    } digit_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_wen   = 1'b0;
    logic [RW-1:0]               cfg_wdata = '0;
    logic                        in_valid  = 1'b0;
    logic [VW-1:0]               number    = '0;
    logic                        out_ready = 1'b0;
    logic                        in_ready;
    logic                        out_valid;
    logic [itrd_pkg::CHAR_W-1:0] char_code;
    logic                        is_last;

    // stimulus and expectation stores
    logic [VW-1:0]       numbers_to_send[$];
    digit_t              digits_due[$];
    digit_t              want;

    // radix as the block holds it, updated with each register write
    logic [RW-1:0]       radix_shadow = itrd_pkg::RADIX_RESET;

    // pacing, in percent of cycles spent idle
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;

    // set at a rising edge when the input item was taken there
    logic                number_taken = 1'b0;

    // receiver hold-off, one shot
    logic                hold_req    = 1'b0;
    logic                hold_active = 1'b0;
    logic                hold_done   = 1'b0;
    int                  hold_left   = 0;

    int                  errors = 0;

    integer_to_radix_digits_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .number    (number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .is_last   (is_last)
    );

    always #5 clk = ~clk;

    // Digit string of one value: repeated division by the clamped radix,
    // remainders kept least significant first, then queued most significant
    // first. Zero still yields one digit. Only the low MAX_DIGITS digits
    // would be kept, which the default width never reaches.
    function automatic void predict_digits(input logic [VW-1:0] value,
                                           input logic [RW-1:0] radix_reg);
        logic [RW-1:0]                base;
        logic [VW-1:0]                rest;
        logic [VW-1:0]                rem_full;
        logic [itrd_pkg::DIGIT_W-1:0] rems[itrd_pkg::MAX_DIGITS_DEF];
        logic [itrd_pkg::DIGIT_W-1:0] dv;
        int                           cnt;
        digit_t                       d;
        base = radix_reg;
        if (base < itrd_pkg::RADIX_MIN)
        begin
            base = itrd_pkg::RADIX_MIN;
        end
        if (base > itrd_pkg::RADIX_MAX)
        begin
            base = itrd_pkg::RADIX_MAX;
        end
        rest = value;
        cnt  = 0;
        do
        begin
            if (cnt < itrd_pkg::MAX_DIGITS_DEF)
            begin
                rem_full  = rest % base;
                rems[cnt] = rem_full[itrd_pkg::DIGIT_W-1:0];
                cnt++;
            end
            rest = rest / base;
        end
        while (rest != 0);
        for (int k = 0; k < cnt; k++)
        begin
            dv = rems[cnt - 1 - k];
            if (dv > itrd_pkg::DIGIT_TOP)
            begin
                dv = itrd_pkg::DIGIT_TOP;
            end
            d.char_code = (dv < itrd_pkg::DIGIT_TEN) ?
                          itrd_pkg::CHAR_ZERO + {1'b0, dv} :
                          itrd_pkg::CHAR_ALPHA + {1'b0, dv};
            d.is_last   = (k == cnt - 1);
            digits_due.push_back(d);
        end
    endfunction

    // mix of full-width, narrowed, small and all-ones values
    function automatic logic [VW-1:0] random_number();
        int            w;
        logic [VW-1:0] v;
        v = VW'($urandom);
        case ($urandom_range(0, 3))
            0: ;
            1:
            begin
                w = $urandom_range(1, VW);
                v = v >> (VW - w);
            end
            2: v = VW'($urandom_range(0, 1500));
            default: v = {VW{1'b1}} >> $urandom_range(0, VW - 1);
        endcase
        return v;
    endfunction

    // Sampling side, rising edge: predict on every accepted input item,
    // check every accepted output item against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            number_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                predict_digits(number, radix_shadow);
            end
            if (out_valid && out_ready)
            begin
                if (digits_due.size() == 0)
                begin
                    $display("%0t: unexpected item, char %0d last %0d",
                             $time, char_code, is_last);
                    errors++;
                end
                else
                begin
                    want = digits_due.pop_front();
                    if (char_code !== want.char_code)
                    begin
                        $display("%0t: char_code expected %0d got %0d",
                                 $time, want.char_code, char_code);
                        errors++;
                    end
                    if (is_last !== want.is_last)
                    begin
                        $display("%0t: is_last expected %0d got %0d",
                                 $time, want.is_last, is_last);
                        errors++;
                    end
                end
            end
        end
    end

    // Sender, falling edge: hold the item until it is taken, then either
    // offer the next pending number or stay idle.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || number_taken)
            begin
                if (numbers_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    number   <= numbers_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver, falling edge: random stalls, or flat out low during the hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_active)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Hold-off counter, its own process; fires once when requested.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_active)
            begin
                if (hold_left == 1)
                begin
                    hold_active <= 1'b0;
                end
                hold_left <= hold_left - 1;
            end
            else if (hold_req && !hold_done)
            begin
                hold_active <= 1'b1;
                hold_done   <= 1'b1;
                hold_left   <= HOLD_CYCLES;
            end
        end
    end

    // Block is drained: nothing pending, nothing offered, nothing owed.
    // Checked at the rising edge, where all three are settled. The slack
    // after it covers the sequencer going back to idle.
    task automatic wait_drained();
        while (numbers_to_send.size() != 0 || in_valid || digits_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    // radix write, only once the block is drained
    task automatic program_radix(input logic [RW-1:0] value);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen      <= 1'b0;
        radix_shadow = value;
    endtask

    task automatic set_pacing(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial
    begin
        logic [RW-1:0] r;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_pacing(9, 86);

        // directed: reset radix of ten, zero, one digit, carry, widest value
        numbers_to_send.push_back(31'd0);
        numbers_to_send.push_back(31'd9);
        numbers_to_send.push_back(31'd10);
        numbers_to_send.push_back(31'h7FFF_FFFF);
        numbers_to_send.push_back(31'd1000000000);

        // radix two: longest strings
        program_radix(6'd2);
        numbers_to_send.push_back(31'd0);
        numbers_to_send.push_back(31'd1);
        numbers_to_send.push_back(31'h7FFF_FFFF);
        numbers_to_send.push_back(31'h4000_0000);

        // radix 36: top digit Z and its rollover
        program_radix(6'd36);
        numbers_to_send.push_back(31'd35);
        numbers_to_send.push_back(31'd36);
        numbers_to_send.push_back(31'h7FFF_FFFF);

        // radix below range, 0 and 1, act as two
        program_radix(6'd0);
        numbers_to_send.push_back(31'd5);
        program_radix(6'd1);
        numbers_to_send.push_back(31'd3);

        // radix above range, 37 and 63, act as 36
        program_radix(6'd37);
        numbers_to_send.push_back(31'd1295);
        program_radix(6'd63);
        numbers_to_send.push_back(31'h7FFF_FFFF);

        // hex, letters A-F
        program_radix(6'd16);
        numbers_to_send.push_back(31'h0ABC_DEF0);
        numbers_to_send.push_back(31'h7FFF_FFFF);

        // random phases, each with its own radix
        for (int phase = 0; phase < 10; phase++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                r = RW'($urandom_range(itrd_pkg::RADIX_MIN, itrd_pkg::RADIX_MAX));
            end
            else
            begin
                r = RW'($urandom_range(0, 63));
            end
            program_radix(r);
            if (phase == 4)
            begin
                set_pacing(86, 9);
            end
            if (phase == 7)
            begin
                // no idling; receiver stalls long while the sender keeps offering
                set_pacing(0, 0);
                hold_req = 1'b1;
            end
            repeat (15) numbers_to_send.push_back(random_number());
        end

        wait_drained();
        repeat (100) @(negedge clk);
        if (digits_due.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time, digits_due.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("tb_integer_to_radix_digits_top: clean");
        end
        else
        begin
            $display("tb_integer_to_radix_digits_top: errors");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #12ms;
        $display("%0t: run limit reached", $time);
        $display("tb_integer_to_radix_digits_top: errors");
        $finish;
    end

endmodule
